### hw/rtl/greedy_line_wrapper_assert.svh
// ----------------------------------------------------------------------------
// greedy_line_wrapper assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions. The using
// module must provide clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef GREEDY_LINE_WRAPPER_ASSERT_SVH
`define GREEDY_LINE_WRAPPER_ASSERT_SVH

// same-cycle implication
`define GLW_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GLW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/glw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glw_pkg
// Shared types and constants of the greedy line wrapper.
// ----------------------------------------------------------------------------
package glw_pkg;

	// character codes
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// field widths
	localparam int COL_BITS  = 9;
	localparam int REC_BITS  = 24;
	localparam int BYTE_BITS = 8;

	// parameter defaults
	localparam int DEF_MAX_COLUMNS = 256;
	localparam int DEF_OFFSET_BITS = 24;
	localparam int DEF_TAB_STOP    = 8;

	// command queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	// register map (index taken from paddr[2])
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic [COL_BITS-1:0] COLUMNS_RESET = 9'd80;

	// classified command handed from front to back
	typedef enum logic [2:0] {
		K_CHAR    = 3'd0,
		K_SPACE   = 3'd1,
		K_TAB     = 3'd2,
		K_TERM    = 3'd3,
		K_SWALLOW = 3'd4,
		K_END     = 3'd5
	} kind_t;

	// terminator just seen by the front
	typedef enum logic [1:0] {
		PT_NONE = 2'd0,
		PT_CR   = 2'd1,
		PT_LF   = 2'd2
	} pend_t;

	// queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

### hw/rtl/glw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glw_front
// Accepts input words, pairs CR/LF terminators and classifies each byte.
// ----------------------------------------------------------------------------
module glw_front
	import glw_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [BYTE_BITS-1:0] s_tdata,   // [7:0] text_byte
	input  wire logic [0:0]           s_tuser,   // [0] func
	input  wire q_stat_t              q_stat,
	output logic                      push,
	output kind_t                     kind
);

	pend_t pend_q, pend_d;

	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;

	// classify the byte
	always_comb begin
		pend_d = PT_NONE;
		if (s_tuser[0]) begin
			kind = K_END;
		end else if ((pend_q == PT_CR && s_tdata == CH_LF) ||
			(pend_q == PT_LF && s_tdata == CH_CR)) begin
			kind = K_SWALLOW;
		end else if (s_tdata == CH_CR) begin
			kind   = K_TERM;
			pend_d = PT_CR;
		end else if (s_tdata == CH_LF) begin
			kind   = K_TERM;
			pend_d = PT_LF;
		end else if (s_tdata == CH_TAB) begin
			kind = K_TAB;
		end else if (s_tdata == CH_SPACE) begin
			kind = K_SPACE;
		end else begin
			kind = K_CHAR;
		end
	end

	// pending terminator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PT_NONE;
		end else if (push) begin
			pend_q <= pend_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/glw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glw_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module glw_queue
	import glw_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire kind_t push_kind,
	input  wire logic  pop,
	output kind_t      head_kind,
	output q_stat_t    stat
);

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	kind_t          ent_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] cnt_q;

	assign stat.full  = (cnt_q == QCW'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head_kind  = ent_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_kind;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/glw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glw_back
// Column tracking, line breaking, tab-mark replay and the output register.
// ----------------------------------------------------------------------------
module glw_back
	import glw_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int OFFSET_BITS = DEF_OFFSET_BITS,
	parameter int TAB_STOP    = DEF_TAB_STOP
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [COL_BITS-1:0]   columns,
	input  wire kind_t                 q_kind,
	input  wire q_stat_t               q_stat,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [2*REC_BITS-1:0]      m_tdata,   // [23:0] line_offset, [47:24] line_length
	output logic                       m_tlast    // final_line
);

	localparam int CW = $clog2(MAX_COLUMNS + TAB_STOP + 1);
	localparam int PW = $clog2(TAB_STOP);
	localparam int FW = $clog2(MAX_COLUMNS + 1);
	localparam int AW = $clog2(MAX_COLUMNS);
	localparam int XW = (CW > COL_BITS) ? CW : COL_BITS;
	localparam int OB = OFFSET_BITS;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_REPLAY = 3'b010,
		ST_CHECK  = 3'b100
	} bstate_t;

	// column and its phase within the tab stop
	typedef struct packed {
		logic [CW-1:0] col;
		logic [PW-1:0] ph;
	} colst_t;

	function automatic colst_t adv(colst_t c, logic tab);
		colst_t r;
		if (tab) begin
			r.col = c.col + CW'(TAB_STOP) - CW'(c.ph);
			r.ph  = '0;
		end else begin
			r.col = c.col + 1'b1;
			r.ph  = (c.ph == PW'(TAB_STOP - 1)) ? '0 : c.ph + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [REC_BITS-1:0] to_rec(logic [OB-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[REC_BITS-1:0];
	endfunction

	bstate_t       state_q, state_d;
	logic [OB-1:0] pos_q, pos_d, lb_q, lb_d, sp_q, sp_d;
	colst_t        cs_q, cs_d;
	logic          ss_q, ss_d;
	logic [FW-1:0] fill_q, fill_d, issue_q, issue_d;
	logic          cur_tab_q, cur_tab_d, cur_sp_q, cur_sp_d;
	logic          rd_vld_q, rd_vld_d, rd_en;
	logic          mark_rd_q;
	logic          mark_mem [MAX_COLUMNS];

	logic          out_vld_q, fin_q;
	logic [REC_BITS-1:0] start_q, len_q;

	logic [XW-1:0] col_raw, lim;
	logic          tab_sel, sp_sel, brk, out_free;
	colst_t        nxt, nz;
	logic          emit, e_fin;
	logic [OB-1:0] e_len;
	logic          fin_en, mem_we;
	colst_t        fin_cs;

	// clamp the column limit
	assign col_raw = XW'(columns);
	assign lim = (col_raw < XW'(2)) ? XW'(2) :
		(col_raw > XW'(MAX_COLUMNS)) ? XW'(MAX_COLUMNS) : col_raw;

	// break test for the byte in hand
	assign tab_sel  = (state_q == ST_CHECK) ? cur_tab_q : (q_kind == K_TAB);
	assign sp_sel   = (state_q == ST_CHECK) ? cur_sp_q : (q_kind == K_SPACE);
	assign nxt      = adv(cs_q, tab_sel);
	assign nz       = adv('0, tab_sel);
	assign brk      = (XW'(nxt.col) >= lim) && (cs_q.col != '0);
	assign out_free = !out_vld_q || m_tready;
	assign rd_en    = (state_q == ST_REPLAY) && (issue_q < fill_q);

	// next-state logic
	always_comb begin
		state_d   = state_q;
		pos_d     = pos_q;
		lb_d      = lb_q;
		sp_d      = sp_q;
		cs_d      = cs_q;
		ss_d      = ss_q;
		fill_d    = fill_q;
		issue_d   = issue_q;
		cur_tab_d = cur_tab_q;
		cur_sp_d  = cur_sp_q;
		rd_vld_d  = 1'b0;
		q_pop     = 1'b0;
		emit      = 1'b0;
		e_fin     = 1'b0;
		e_len     = pos_q - lb_q;
		fin_en    = 1'b0;
		fin_cs    = nxt;
		mem_we    = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					unique case (q_kind) inside
						K_END: begin
							if (out_free) begin
								q_pop  = 1'b1;
								emit   = 1'b1;
								e_fin  = 1'b1;
								pos_d  = '0;
								lb_d   = '0;
								sp_d   = '0;
								cs_d   = '0;
								ss_d   = 1'b0;
								fill_d = '0;
							end
						end
						K_SWALLOW: begin
							q_pop = 1'b1;
							pos_d = pos_q + 1'b1;
							lb_d  = pos_q + 1'b1;
						end
						K_TERM: begin
							if (out_free) begin
								q_pop  = 1'b1;
								emit   = 1'b1;
								lb_d   = pos_q + 1'b1;
								pos_d  = pos_q + 1'b1;
								cs_d   = '0;
								ss_d   = 1'b0;
								fill_d = '0;
							end
						end
						K_TAB, K_SPACE, K_CHAR: begin
							if (!brk) begin
								q_pop  = 1'b1;
								fin_en = 1'b1;
							end else if (out_free) begin
								q_pop = 1'b1;
								emit  = 1'b1;
								if (ss_q) begin
									// soft break after the last space, then replay
									e_len     = sp_q + 1'b1 - lb_q;
									lb_d      = sp_q + 1'b1;
									ss_d      = 1'b0;
									cs_d      = '0;
									cur_tab_d = (q_kind == K_TAB);
									cur_sp_d  = (q_kind == K_SPACE);
									issue_d   = '0;
									state_d   = ST_REPLAY;
								end else begin
									// hard break before this byte
									lb_d   = pos_q;
									fill_d = '0;
									fin_en = 1'b1;
									fin_cs = nz;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_REPLAY: begin
				if (rd_en) begin
					issue_d  = issue_q + 1'b1;
					rd_vld_d = 1'b1;
				end
				if (rd_vld_q) begin
					cs_d = adv(cs_q, mark_rd_q);
				end
				if (issue_q == fill_q && !rd_vld_q) begin
					fill_d  = '0;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!brk) begin
					fin_en  = 1'b1;
					state_d = ST_IDLE;
				end else if (out_free) begin
					emit    = 1'b1;
					lb_d    = pos_q;
					fin_en  = 1'b1;
					fin_cs  = nz;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// take the byte onto the line
		if (fin_en) begin
			cs_d  = fin_cs;
			pos_d = pos_q + 1'b1;
			if (sp_sel) begin
				ss_d   = 1'b1;
				sp_d   = pos_q;
				fill_d = '0;
			end else if (ss_q && fill_q < FW'(MAX_COLUMNS)) begin
				mem_we = 1'b1;
				fill_d = fill_q + 1'b1;
			end
		end
	end

	// tab marks since the last space
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mark_mem[fill_q[AW-1:0]] <= tab_sel;
		end
		if (rd_en) begin
			mark_rd_q <= mark_mem[issue_q[AW-1:0]];
		end
	end

	// control and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			lb_q      <= '0;
			sp_q      <= '0;
			cs_q      <= '0;
			ss_q      <= 1'b0;
			fill_q    <= '0;
			issue_q   <= '0;
			cur_tab_q <= 1'b0;
			cur_sp_q  <= 1'b0;
			rd_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pos_q     <= pos_d;
			lb_q      <= lb_d;
			sp_q      <= sp_d;
			cs_q      <= cs_d;
			ss_q      <= ss_d;
			fill_q    <= fill_d;
			issue_q   <= issue_d;
			cur_tab_q <= cur_tab_d;
			cur_sp_q  <= cur_sp_d;
			rd_vld_q  <= rd_vld_d;
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// output record register
	always_ff @(posedge clk) begin
		if (emit) begin
			start_q <= to_rec(lb_q);
			len_q   <= to_rec(e_len);
			fin_q   <= e_fin;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {len_q, start_q};
	assign m_tlast  = fin_q;

endmodule
`default_nettype wire

### hw/rtl/greedy_line_wrapper.sv
// Path: a word is accepted into the command queue; the line record it closes
// goes into the output register when the back part is idle and the output free.
// Throughput: one byte per cycle while the output is free and no replay runs;
// a soft break replays the marks after the space from the tab-mark memory.
// Reset: asynchronous, active low; clears all line state and the queue,
// columns returns to 80. The tab-mark memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_line_wrapper
// Greedy word wrap of a byte stream into (start, length) line records.
// ----------------------------------------------------------------------------
module greedy_line_wrapper
	import glw_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int OFFSET_BITS = DEF_OFFSET_BITS,
	parameter int TAB_STOP    = DEF_TAB_STOP
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	// text in
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [BYTE_BITS-1:0] s_tdata,   // [7:0] text_byte
	input  wire logic [0:0]           s_tuser,   // [0] func
	// line records out
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [2*REC_BITS-1:0]     m_tdata,   // [23:0] line_offset, [47:24] line_length
	output logic                      m_tlast    // final_line
);

	logic [COL_BITS-1:0] columns_q;
	logic                push, pop;
	kind_t               push_kind, head_kind;
	q_stat_t             q_stat;

	// register file
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COLUMNS) ? 32'(columns_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_COLUMNS) begin
			columns_q <= pwdata[COL_BITS-1:0];
		end
	end

	glw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.kind     (push_kind)
	);

	glw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_kind (push_kind),
		.pop       (pop),
		.head_kind (head_kind),
		.stat      (q_stat)
	);

	glw_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.OFFSET_BITS (OFFSET_BITS),
		.TAB_STOP    (TAB_STOP)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.columns  (columns_q),
		.q_kind   (head_kind),
		.q_stat   (q_stat),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

### hw/rtl/glw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glw_checker
// Port-level checks of the line wrapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "greedy_line_wrapper_assert.svh"

module glw_checker
	import glw_pkg::*;
#(
	parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 psel,
	input wire logic                 penable,
	input wire logic                 pwrite,
	input wire logic [2:0]           paddr,
	input wire logic [31:0]          pwdata,
	input wire logic [31:0]          prdata,
	input wire logic                 pready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [2*REC_BITS-1:0] m_tdata,
	input wire logic                 m_tlast
);

	localparam logic [REC_BITS-1:0] DMASK = (OFFSET_BITS >= REC_BITS) ?
		{REC_BITS{1'b1}} : REC_BITS'((64'd1 << OFFSET_BITS) - 64'd1);

	logic                out_acc, cfg_wr;
	logic                last_fin_q;
	logic [REC_BITS-1:0] prev_end_q, gap;

	assign out_acc = m_tvalid && m_tready;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign gap     = (m_tdata[REC_BITS-1:0] - prev_end_q) & DMASK;

	// track where the previous record ended and whether it closed a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_fin_q <= 1'b1;
			prev_end_q <= '0;
		end else if (out_acc) begin
			last_fin_q <= m_tlast;
			prev_end_q <= m_tdata[REC_BITS-1:0] + m_tdata[2*REC_BITS-1:REC_BITS];
		end
	end

	`GLW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "record changed while stalled")
	`GLW_ASSERT_IMP(a_text_start, out_acc && last_fin_q, m_tdata[REC_BITS-1:0] == '0, "first line of a text not at offset zero")
	`GLW_ASSERT_IMP(a_contig, out_acc && !last_fin_q, gap <= REC_BITS'(2), "line records not contiguous")
	`GLW_ASSERT_NEXT(a_cfg_rd, cfg_wr && paddr[2] == REG_COLUMNS, paddr[2] != REG_COLUMNS || prdata == 32'($past(pwdata[COL_BITS-1:0])), "columns readback mismatch")

endmodule

bind greedy_line_wrapper glw_checker #(
	.OFFSET_BITS (OFFSET_BITS)
) u_glw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata),
	.pready   (pready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

### verif/greedy_line_wrapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_line_wrapper_tb
// Self-checking bench for the greedy line wrapper. A tracker class keeps its
// own copy of the wrap state and predicts the (start, length, final) line
// records for every accepted text word. Every record the block emits is
// checked against the oldest prediction. Directed text covers the pair
// swallowing, tab stops, breaks before and after spaces and empty lines.
// Random text follows under several column limits, with bursty input and a
// stalling receiver.
// ----------------------------------------------------------------------------
module greedy_line_wrapper_tb;
	import glw_pkg::*;

	localparam int SETTLE_CYCLES = DEF_MAX_COLUMNS + 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 12;
	localparam logic [8:0] END_ITEM = 9'h100;

	typedef struct packed {
		logic [REC_BITS-1:0] line_offset;
		logic [REC_BITS-1:0] line_length;
		logic                final_line;
	} line_rec_t;

	// wrap state tracker and queue of line records still due
	class wrap_tracker;
		logic [COL_BITS-1:0] columns;
		logic [REC_BITS-1:0] byte_pos;
		logic [REC_BITS-1:0] line_begin;
		logic [REC_BITS-1:0] space_pos;
		int unsigned         col_count;
		bit                  space_seen;
		pend_t               pending;
		bit                  tab_marks[DEF_MAX_COLUMNS];
		int unsigned         marks_fill;
		line_rec_t           due_lines[$];
		int unsigned         errors;

		function new();
			columns = COLUMNS_RESET;
			errors  = 0;
			clear_text();
		endfunction

		function void clear_text();
			byte_pos   = '0;
			line_begin = '0;
			space_pos  = '0;
			col_count  = 0;
			space_seen = 1'b0;
			pending    = PT_NONE;
			marks_fill = 0;
		endfunction

		function void set_columns(logic [COL_BITS-1:0] value);
			columns = value;
		endfunction

		function int unsigned step_column(int unsigned col, bit tab);
			int unsigned n;
			n = col + 1;
			if (tab) n = ((n + DEF_TAB_STOP - 1) / DEF_TAB_STOP) * DEF_TAB_STOP;
			return n;
		endfunction

		function void close_line(logic [REC_BITS-1:0] start, logic [REC_BITS-1:0] stop,
				bit fin);
			line_rec_t rec;
			rec.line_offset = start;
			rec.line_length = stop - start;
			rec.final_line  = fin;
			due_lines.push_back(rec);
		endfunction

		// one accepted word: update state, queue the records it closes
		function void take_word(bit is_end, logic [7:0] b);
			logic [REC_BITS-1:0] pos;
			logic [7:0]          other;
			int unsigned         lim;
			int unsigned         nxt;
			int unsigned         k;
			bit                  tab;
			pos = byte_pos;
			if (is_end) begin
				close_line(line_begin, pos, 1'b1);
				clear_text();
				return;
			end
			// second half of a CR/LF or LF/CR pair is swallowed
			if (pending != PT_NONE) begin
				other = (pending == PT_CR) ? CH_LF : CH_CR;
				pending = PT_NONE;
				if (b == other) begin
					byte_pos   = pos + 1'b1;
					line_begin = byte_pos;
					return;
				end
			end
			if (b == CH_LF || b == CH_CR) begin
				close_line(line_begin, pos, 1'b0);
				pending    = (b == CH_CR) ? PT_CR : PT_LF;
				line_begin = pos + 1'b1;
				col_count  = 0;
				space_seen = 1'b0;
				marks_fill = 0;
				byte_pos   = pos + 1'b1;
				return;
			end
			tab = (b == CH_TAB);
			lim = columns;
			if (lim < 2) lim = 2;
			if (lim > DEF_MAX_COLUMNS) lim = DEF_MAX_COLUMNS;
			nxt = step_column(col_count, tab);
			// a byte at column 0 always fits
			if (nxt >= lim && col_count != 0) begin
				if (space_seen) begin
					// soft break after the space, replay what followed it
					close_line(line_begin, space_pos + 1'b1, 1'b0);
					line_begin = space_pos + 1'b1;
					space_seen = 1'b0;
					col_count  = 0;
					for (k = 0; k < marks_fill && k < DEF_MAX_COLUMNS; k++)
						col_count = step_column(col_count, tab_marks[k]);
					marks_fill = 0;
					nxt = step_column(col_count, tab);
				end
				if (nxt >= lim && col_count != 0) begin
					// hard break before this byte
					close_line(line_begin, pos, 1'b0);
					line_begin = pos;
					col_count  = 0;
					marks_fill = 0;
					nxt = step_column(0, tab);
				end
			end
			col_count = nxt;
			if (b == CH_SPACE) begin
				space_seen = 1'b1;
				space_pos  = pos;
				marks_fill = 0;
			end else if (space_seen && marks_fill < DEF_MAX_COLUMNS) begin
				tab_marks[marks_fill] = tab;
				marks_fill++;
			end
			byte_pos = pos + 1'b1;
		endfunction

		function void match_line(logic [REC_BITS-1:0] start, logic [REC_BITS-1:0] len,
				logic fin);
			line_rec_t want;
			if (due_lines.size() == 0) begin
				$error("line record with none due: start %0d length %0d final %0b",
					start, len, fin);
				errors++;
				return;
			end
			want = due_lines.pop_front();
			if (start !== want.line_offset) begin
				$error("line_offset: expected %0d, got %0d", want.line_offset, start);
				errors++;
			end
			if (len !== want.line_length) begin
				$error("line_length: expected %0d, got %0d", want.line_length, len);
				errors++;
			end
			if (fin !== want.final_line) begin
				$error("final_line: expected %0b, got %0b", want.final_line, fin);
				errors++;
			end
		endfunction

		function int unsigned lines_due();
			return due_lines.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [2:0]            paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [BYTE_BITS-1:0]  s_tdata;   // [7:0] text_byte
	logic [0:0]            s_tuser;   // [0] func
	logic                  m_tvalid;
	logic                  m_tready;
	logic [2*REC_BITS-1:0] m_tdata;   // [23:0] line_offset, [47:24] line_length
	logic                  m_tlast;   // final_line

	wrap_tracker tracker;
	bit          hold_request;
	bit          holding;

	greedy_line_wrapper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// check every record the block hands over
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_line(m_tdata[REC_BITS-1:0], m_tdata[2*REC_BITS-1:REC_BITS], m_tlast);
	end

	// receiver: stall pattern in random spans, one long hold on request
	initial begin
		int unsigned style;
		int unsigned span;
		m_tready = 1'b0;
		holding  = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				holding = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				holding = 1'b0;
			end else begin
				style = $urandom_range(3);
				span  = $urandom_range(8, 80);
				repeat (span) begin
					case (style)
						0: begin
							m_tready <= 1'b1;
						end
						1: begin
							m_tready <= $urandom_range(1);
						end
						2: begin
							m_tready <= ($urandom_range(3) == 0);
						end
						default: begin
							m_tready <= ($urandom_range(7) != 0);
						end
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// register write, setup then access
	task automatic write_columns(input int unsigned value);
		logic [31:0] word;
		word = {23'($urandom_range(32'h7F_FFFF)), value[COL_BITS-1:0]};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_COLUMNS, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_columns(value[COL_BITS-1:0]);
	endtask

	// offer one word and wait until it is taken
	task automatic send_word(input bit is_end, input logic [7:0] b);
		s_tvalid <= 1'b1;
		s_tuser  <= is_end;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_word(is_end, b);
	endtask

	task automatic send_list(input logic [8:0] words[$]);
		foreach (words[i]) send_word(words[i][8], words[i][7:0]);
	endtask

	// mostly lowercase words with spaces, some tabs, terminators, any byte
	function automatic void pick_text(output bit is_end, output logic [7:0] b);
		int unsigned r;
		r = $urandom_range(99);
		is_end = 1'b0;
		if (r < 55)
			b = 8'h61 + 8'($urandom_range(25));
		else if (r < 72)
			b = CH_SPACE;
		else if (r < 78)
			b = CH_TAB;
		else if (r < 82)
			b = CH_LF;
		else if (r < 86)
			b = CH_CR;
		else if (r < 97)
			b = 8'($urandom_range(255));
		else begin
			is_end = 1'b1;
			b = 8'($urandom_range(255));
		end
	endfunction

	// random text in bursts with gaps, closed by an end word
	task automatic send_random(input int unsigned count);
		int unsigned burst;
		int unsigned gap;
		bit          is_end;
		logic [7:0]  b;
		burst = 0;
		for (int unsigned i = 0; i < count; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 16);
				gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					s_tdata  <= 8'($urandom_range(255));
					repeat (gap) @(posedge clk);
				end
			end
			pick_text(is_end, b);
			send_word(is_end, b);
			burst--;
		end
		send_word(1'b1, 8'($urandom_range(255)));
	endtask

	// stop sending until every record is in, then let replays settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.lines_due() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// main sequence
	initial begin
		int unsigned col_plan[10];
		logic [8:0]  at_default[$];
		logic [8:0]  at_ten[$];
		logic [8:0]  at_two[$];
		col_plan   = '{2, 256, 0, 511, 1, 8, 12, 20, 3, 80};
		at_default = '{{1'b0, 8'h68}, {1'b0, 8'h69}, END_ITEM};
		// empty text, space at offset 0, soft break whose replay still
		// overflows, extreme bytes, pairs swallowed and not swallowed
		at_ten     = '{END_ITEM, {1'b0, CH_SPACE}, {1'b0, 8'h61}, {1'b0, 8'h62},
			{1'b0, CH_SPACE}, {1'b0, 8'h63}, {1'b0, CH_TAB}, {1'b0, 8'h64},
			{1'b0, 8'h65}, {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, CH_CR},
			{1'b0, CH_LF}, {1'b0, CH_LF}, {1'b0, CH_CR}, {1'b0, CH_CR},
			{1'b0, CH_CR}, {1'b0, 8'h78}, END_ITEM};
		// tab wider than the line at column 0
		at_two     = '{{1'b0, CH_TAB}, {1'b0, CH_TAB}, {1'b0, 8'h79}, END_ITEM};
		tracker      = new();
		hold_request = 1'b0;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed text
		send_list(at_default);
		drain();
		write_columns(10);
		send_list(at_ten);
		drain();
		write_columns(2);
		send_list(at_two);
		drain();

		// random text under several limits
		for (int p = 0; p < 10; p++) begin
			if (p == 8)
				write_columns($urandom_range(3, 40));
			else
				write_columns(col_plan[p]);
			if (p == 5) begin
				// receiver holds off while text keeps coming
				hold_request = 1'b1;
				while (!holding) @(posedge clk);
			end
			send_random(PHASE_ITEMS);
			drain();
		end

		if (tracker.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### greedy_line_wrapper.f
+incdir+hw/rtl
hw/rtl/glw_pkg.sv
hw/rtl/glw_front.sv
hw/rtl/glw_queue.sv
hw/rtl/glw_back.sv
hw/rtl/greedy_line_wrapper.sv
hw/rtl/glw_checker.sv
verif/greedy_line_wrapper_tb.sv
